// ===== design/yenc_pkg.sv =====
// ----------------------------------------------------------------------------
// yenc_pkg
// Shared types and constants of the yEnc byte encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package yenc_pkg;

  localparam int          QueueDepth     = 4;
  localparam int          CfgAddrWidth   = 2;
  localparam int          ColWidth       = 9;
  localparam logic [7:0]  LineLenReset   = 8'd128;
  localparam logic [7:0]  EncOffset      = 8'd42;
  localparam logic [7:0]  EscOffset      = 8'd64;
  localparam logic [7:0]  ChNul          = 8'h00;
  localparam logic [7:0]  ChTab          = 8'h09;
  localparam logic [7:0]  ChLf           = 8'h0A;
  localparam logic [7:0]  ChCr           = 8'h0D;
  localparam logic [7:0]  ChDot          = 8'h2E;
  localparam logic [7:0]  ChEq           = 8'h3D;
  localparam logic [CfgAddrWidth-1:0] RegLineLength = '0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_part;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0] char;
    logic       brk;
    logic       esc;
    logic       last;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/yenc_front.sv =====
// ----------------------------------------------------------------------------
// yenc_front
// Accepts raw bytes, tracks the line column and classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yenc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     line_len,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire yenc_pkg::in_t  in_data,
  input  wire logic           q_full,
  output logic                push,
  output yenc_pkg::cmd_t      push_cmd
);

  logic [yenc_pkg::ColWidth-1:0] col_r, col_nxt, col_base;
  logic [7:0]                    enc;
  logic                          brk;
  logic                          esc;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    brk      = col_r >= {1'b0, line_len};
    col_base = brk ? '0 : col_r;
    enc      = in_data.data_byte + yenc_pkg::EncOffset;
    esc      = (enc == yenc_pkg::ChNul) || (enc == yenc_pkg::ChTab) ||
               (enc == yenc_pkg::ChLf) || (enc == yenc_pkg::ChCr) ||
               (enc == yenc_pkg::ChEq) ||
               ((enc == yenc_pkg::ChDot) && (col_base == '0));
    push_cmd.char = esc ? enc + yenc_pkg::EscOffset : enc;
    push_cmd.brk  = brk;
    push_cmd.esc  = esc;
    push_cmd.last = in_data.last_byte;
    if (in_data.last_byte) begin
      col_nxt = '0;
    end else begin
      col_nxt = col_base + (esc ? yenc_pkg::ColWidth'(2) : yenc_pkg::ColWidth'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/yenc_queue.sv =====
// ----------------------------------------------------------------------------
// yenc_queue
// Small fifo of classified bytes between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yenc_queue #(
  parameter int DEPTH = yenc_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire yenc_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output yenc_pkg::cmd_t       head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  yenc_pkg::cmd_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full       = count_r == CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/yenc_back.sv =====
// ----------------------------------------------------------------------------
// yenc_back
// Expands each classified byte into its text bytes, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yenc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire yenc_pkg::cmd_t  head_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output yenc_pkg::out_t       out_data
);

  typedef enum logic [2:0] {
    PH_START,
    PH_CR,
    PH_LF,
    PH_EQ,
    PH_DATA,
    PH_TCR,
    PH_TLF
  } phase_t;

  phase_t          st_r, cur, nxt;
  logic            out_valid_r;
  yenc_pkg::out_t  out_r;
  yenc_pkg::out_t  res;
  logic            step;
  logic            done;

  always_comb begin
    if (st_r == PH_START) begin
      if (head_cmd.brk) begin
        cur = PH_CR;
      end else if (head_cmd.esc) begin
        cur = PH_EQ;
      end else begin
        cur = PH_DATA;
      end
    end else begin
      cur = st_r;
    end

    done = ((cur == PH_DATA) && !head_cmd.last) || (cur == PH_TLF);

    case (cur)
      PH_CR:   nxt = PH_LF;
      PH_LF:   nxt = head_cmd.esc ? PH_EQ : PH_DATA;
      PH_EQ:   nxt = PH_DATA;
      PH_DATA: nxt = PH_TCR;
      PH_TCR:  nxt = PH_TLF;
      default: nxt = PH_START;
    endcase

    case (cur)
      PH_CR, PH_TCR: res.out_byte = yenc_pkg::ChCr;
      PH_LF, PH_TLF: res.out_byte = yenc_pkg::ChLf;
      PH_EQ:         res.out_byte = yenc_pkg::ChEq;
      default:       res.out_byte = head_cmd.char;
    endcase
    res.last_of_run = done;
    res.end_of_part = cur == PH_TLF;

    // output register takes a new byte whenever a classified byte waits and the register is empty or drained
    step = head_valid && (!out_valid_r || out_ready);
    pop  = step && done;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= PH_START;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        st_r        <= done ? PH_START : nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (step) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/yenc_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// yenc_byte_encoder
// yEnc data-line encoder: raw bytes in, encoded text bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one raw byte per request, with last_byte
//   set on the final byte of a part. out_valid/out_ready/out_data carry one
//   text byte per request: encoded bytes, '=' escapes and CR LF breaks;
//   last_of_run marks the final byte produced by an input request and
//   end_of_part marks the closing LF of the part.
//   The APB port holds line_length at address 0 (reset 128); write it only
//   while the encoder is idle.
//   The queue and then the output register lie between the acceptance of
//   a request and its first text byte. The back end emits one text byte
//   per cycle while out_ready allows; a request yields 1 to 6 text bytes
//   (2 for an escape, +2 for a line break, +2 for the end of a part).
//   A queue of QUEUE_DEPTH classified requests lets input keep flowing
//   while output is busy or stalled. Reset clears the column, the queue
//   and out_valid. When out_ready is low the output byte holds; in_ready
//   drops once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yenc_byte_encoder #(
  parameter int QUEUE_DEPTH = yenc_pkg::QueueDepth
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [yenc_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire yenc_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output yenc_pkg::out_t                         out_data
);

  logic [7:0]      line_len_r;
  logic            wr_en;
  logic            sel_line_len;
  logic            push, pop, q_full, head_valid;
  yenc_pkg::cmd_t  push_cmd, head_cmd;

  assign pready       = 1'b1;
  assign sel_line_len = paddr == yenc_pkg::RegLineLength;
  assign wr_en        = psel && penable && pwrite && pready && sel_line_len;
  assign prdata       = sel_line_len ? {24'd0, line_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= yenc_pkg::LineLenReset;
    end else if (wr_en) begin
      line_len_r <= pwdata[7:0];
    end
  end

  yenc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .line_len (line_len_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  yenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  yenc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
